// File: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the serial packet parser: header characters,
// register map, reset values and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package msp_pkg;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_M      = 8'h4D;
	localparam logic [7:0] CHAR_LT     = 8'h3C;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_FIRST_TYPE  = 1'b0;
	localparam logic REG_SECOND_TYPE = 1'b1;

	localparam logic [7:0] FIRST_TYPE_RST  = 8'd1;
	localparam logic [7:0] SECOND_TYPE_RST = 8'd2;

	typedef struct packed {
		logic start;
		logic type_ld;
		logic body_wr;
		logic chk;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic is_dollar;
		logic is_m;
		logic is_lt;
		logic size_ok;
		logic body_full;
		logic pkt_ok;
		logic out_free;
		logic out_last;
	} status_t;

endpackage

// File: design/msp_cfg.sv
// ----------------------------------------------------------------------------
// msp_cfg
// Register block for the two accepted message type IDs, written and read
// over the APB-style configuration port.
// ----------------------------------------------------------------------------
module msp_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [msp_pkg::PADDR_W-1:0]  paddr,
	input  logic [msp_pkg::PDATA_W-1:0]  pwdata,
	output logic [msp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [7:0]                   first_type_id,
	output logic [7:0]                   second_type_id
);
	import msp_pkg::*;

	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= FIRST_TYPE_RST;
			second_q <= SECOND_TYPE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FIRST_TYPE:  first_q  <= pwdata[7:0];
				REG_SECOND_TYPE: second_q <= pwdata[7:0];
				default:         first_q  <= first_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FIRST_TYPE:  prdata = {{(PDATA_W-8){1'b0}}, first_q};
			REG_SECOND_TYPE: prdata = {{(PDATA_W-8){1'b0}}, second_q};
			default:         prdata = '0;
		endcase
	end

	assign first_type_id  = first_q;
	assign second_type_id = second_q;

endmodule

// File: design/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl
// Framing state machine: matches the header, steps through size, type,
// payload and checksum, and sequences the readout of a passed packet.
// ----------------------------------------------------------------------------
module msp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msp_pkg::status_t sts,
	output msp_pkg::cmd_t    cmd
);
	import msp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOLLAR,
		ST_M,
		ST_LT,
		ST_SIZE,
		ST_BODY,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   acc;

	assign in_ready = (state_q != ST_EMIT);
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_LT:   cmd.start   = acc && sts.size_ok;
			ST_SIZE: cmd.type_ld = acc;
			ST_BODY: begin
				cmd.body_wr = acc && !sts.body_full;
				cmd.chk     = acc && sts.body_full;
			end
			ST_EMIT: cmd.out_ld = sts.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) state_q <= sts.is_dollar ? ST_DOLLAR : ST_IDLE;
				end
				ST_DOLLAR: begin
					if (acc) state_q <= sts.is_m ? ST_M : ST_IDLE;
				end
				ST_M: begin
					if (acc) state_q <= sts.is_lt ? ST_LT : ST_IDLE;
				end
				ST_LT: begin
					if (acc) state_q <= sts.size_ok ? ST_SIZE : ST_IDLE;
				end
				ST_SIZE: begin
					if (acc) state_q <= ST_BODY;
				end
				ST_BODY: begin
					if (acc && sts.body_full) state_q <= sts.pkt_ok ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (sts.out_free && sts.out_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/msp_dp.sv
// ----------------------------------------------------------------------------
// msp_dp
// Parser datapath: length, type and checksum registers, payload buffer with
// registered read, readout pointer and the output register.
// ----------------------------------------------------------------------------
module msp_dp #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  logic [7:0]       first_type_id,
	input  logic [7:0]       second_type_id,
	input  msp_pkg::cmd_t    cmd,
	output msp_pkg::status_t sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       msg_type,
	output logic             route,
	output logic [6:0]       payload_size,
	output logic [5:0]       byte_index,
	output logic [7:0]       payload_byte,
	output logic             has_payload,
	output logic             last
);
	import msp_pkg::*;

	localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0]    mem [BUFFER_DEPTH];
	logic [7:0]    rd_data_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] off_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] ptr_nxt;
	logic [CW-1:0] rd_ptr;
	logic [7:0]    chk_q;
	logic [7:0]    type_q;
	logic          route_q;
	logic          out_valid_q;
	logic          len_zero;
	logic [7:0]    len_ext;
	logic [7:0]    ptr_ext;

	assign len_zero = (len_q == '0);
	assign ptr_nxt  = ptr_q + 1'b1;
	assign rd_ptr   = cmd.chk ? '0 : (cmd.out_ld ? ptr_nxt : ptr_q);
	assign len_ext  = 8'(len_q);
	assign ptr_ext  = 8'(ptr_q);

	always_comb begin
		sts.is_dollar = (in_byte == CHAR_DOLLAR);
		sts.is_m      = (in_byte == CHAR_M);
		sts.is_lt     = (in_byte == CHAR_LT);
		sts.size_ok   = (in_byte <= 8'(BUFFER_DEPTH));
		sts.body_full = (off_q == len_q);
		sts.pkt_ok    = (chk_q == in_byte) &&
		                ((type_q == first_type_id) || (type_q == second_type_id));
		sts.out_free  = !out_valid_q || out_ready;
		sts.out_last  = len_zero || (ptr_nxt == len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			off_q   <= '0;
			ptr_q   <= '0;
			chk_q   <= '0;
			type_q  <= '0;
			route_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				len_q <= in_byte[CW-1:0];
				chk_q <= in_byte;
				off_q <= '0;
			end
			if (cmd.type_ld) begin
				type_q <= in_byte;
				chk_q  <= chk_q ^ in_byte;
			end
			if (cmd.body_wr) begin
				chk_q <= chk_q ^ in_byte;
				off_q <= off_q + 1'b1;
			end
			if (cmd.chk) begin
				ptr_q   <= '0;
				route_q <= (type_q != first_type_id);
			end else if (cmd.out_ld) begin
				ptr_q <= ptr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.body_wr) mem[off_q[AW-1:0]] <= in_byte;
		rd_data_q <= mem[rd_ptr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			msg_type     <= type_q;
			route        <= route_q;
			payload_size <= len_ext[6:0];
			byte_index   <= len_zero ? 6'd0 : ptr_ext[5:0];
			payload_byte <= len_zero ? 8'd0 : rd_data_q;
			has_payload  <= !len_zero;
			last         <= sts.out_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/msp_packet_parser.sv
// ----------------------------------------------------------------------------
// msp_packet_parser
// Byte-serial framer for '$' 'M' '<' size type payload checksum packets.
// Framing: one byte per cycle, in_ready held high outside readout.
// Readout: after the checksum byte is taken, results pass the buffer read
// register, then the single output register, one result per cycle unless held
// back; input stalls until all are loaded (one result for an empty payload).
// Reset returns control state to idle and type IDs to 1 and 2; buffer
// contents stay undefined.
// ----------------------------------------------------------------------------
module msp_packet_parser #(
	parameter int unsigned BUFFER_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   msg_type,
	output logic                         route,
	output logic [6:0]                   payload_size,
	output logic [5:0]                   byte_index,
	output logic [7:0]                   payload_byte,
	output logic                         has_payload,
	output logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [msp_pkg::PADDR_W-1:0]  paddr,
	input  logic [msp_pkg::PDATA_W-1:0]  pwdata,
	output logic [msp_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import msp_pkg::*;

	cmd_t       cmd;
	status_t    sts;
	logic [7:0] first_type_id;
	logic [7:0] second_type_id;

	msp_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.first_type_id  (first_type_id),
		.second_type_id (second_type_id)
	);

	msp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msp_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_byte        (in_byte),
		.first_type_id  (first_type_id),
		.second_type_id (second_type_id),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.msg_type       (msg_type),
		.route          (route),
		.payload_size   (payload_size),
		.byte_index     (byte_index),
		.payload_byte   (payload_byte),
		.has_payload    (has_payload),
		.last           (last)
	);

endmodule
